// File: rtl/core/mslc_pkg.sv
// shared types, codes and widths for the shift-register lookup cache
package mslc_pkg;

	localparam int MAX_SLOTS_DEF = 16;
	localparam int ACTIVE_W      = 5;
	localparam int TAG_W         = 32;
	localparam int HANDLE_W      = 16;
	localparam int MODE_W        = 2;
	localparam int STATUS_W      = 2;
	localparam int IN_DATA_W     = 2 * TAG_W + HANDLE_W;
	localparam int OUT_DATA_W    = 24;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SIZE_ZERO = 2'd2;

	localparam logic [0:0] REG_ACTIVE_SLOTS = 1'b0;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TAG_W-1:0]    key;
		logic [TAG_W-1:0]    sec;
	} slot_t;

	typedef struct packed {
		logic add;
		logic clear;
		logic compare;
	} cell_ctrl_t;

endpackage

// File: rtl/core/mslc_cell.sv
// one cache slot: holds an entry, shifts it on to the next slot and compares its tags
module mslc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mslc_pkg::cell_ctrl_t ctrl,
	input  logic               in_range,
	input  mslc_pkg::slot_t    query,
	input  mslc_pkg::slot_t    prev_slot,
	output mslc_pkg::slot_t    slot,
	output logic               stop,
	output logic               hit
);
	import mslc_pkg::*;

	logic [HANDLE_W-1:0] handle_q;
	logic [TAG_W-1:0]    sec_q;
	logic [TAG_W-1:0]    key_q;
	logic                stop_q;
	logic                hit_q;
	logic                empty;
	logic                match;
	logic                shift;

	assign empty = (handle_q == '0);
	assign match = (sec_q == query.sec) && (key_q == query.key);
	assign shift = ctrl.add && in_range;

	// a zero handle marks the slot empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_q <= '0;
		end else if (ctrl.clear) begin
			handle_q <= '0;
		end else if (shift) begin
			handle_q <= prev_slot.handle;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sec_q <= prev_slot.sec;
			key_q <= prev_slot.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (ctrl.compare) begin
			stop_q <= in_range && (empty || match);
			hit_q  <= in_range && !empty && match;
		end
	end

	assign slot.handle = handle_q;
	assign slot.sec    = sec_q;
	assign slot.key    = key_q;
	assign stop        = stop_q;
	assign hit         = hit_q;

endmodule

// File: rtl/core/mslc_pick.sv
// priority pick of the first slot that ends the lookup scan
module mslc_pick #(
	parameter int N = mslc_pkg::MAX_SLOTS_DEF
) (
	input  logic [N-1:0]                   stop,
	input  logic [N-1:0]                   hitf,
	input  mslc_pkg::slot_t                slots [N],
	output logic                           hit,
	output logic [mslc_pkg::HANDLE_W-1:0]  handle
);
	import mslc_pkg::*;

	logic seen;

	always_comb begin
		seen   = 1'b0;
		hit    = 1'b0;
		handle = '0;
		for (int i = 0; i < N; i++) begin
			if (!seen && stop[i]) begin
				seen = 1'b1;
				if (hitf[i]) begin
					hit    = 1'b1;
					handle = slots[i].handle;
				end
			end
		end
	end

endmodule

// File: rtl/core/mru_shift_lookup_cache.sv
// top level: control, size register, row of slot cells and result register
//
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------------------
// input    | s_tvalid / s_tready     | s_tuser mode, s_tdata section, key, handle
// result   | m_tvalid / m_tready     | m_tdata status, hit, found handle
// config   | psel, penable, pwrite   | paddr, pwdata, prdata (active_slots at 0)
//
// an item passes from one acceptance to the next through capture, the slot row
// (shift on add, tag compare on lookup), then the priority pick into the result
// register. reset empties every slot and sets the size to zero.
// a new request is taken while the previous result waits; the block stalls in
// its last cycle only if that result has still not been taken.
module mru_shift_lookup_cache #(
	parameter int MAX_SLOTS = mslc_pkg::MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mslc_pkg::IN_DATA_W-1:0]    s_tdata,   // section_tag, key_tag, entry_handle
	input  logic [mslc_pkg::MODE_W-1:0]       s_tuser,   // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mslc_pkg::OUT_DATA_W-1:0]   m_tdata,   // status, hit, found_handle, pad
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mslc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mslc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mslc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import mslc_pkg::*;

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int AW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [ACTIVE_W-1:0]   active_q;
	mode_t                 mode_s1;
	slot_t                 item_s1;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                  cfg_wr;
	logic [AW-1:0]         act_ext;
	logic [AW-1:0]         max_ext;
	logic [AW-1:0]         used;
	logic                  add_ok;
	cell_ctrl_t            ctrl;
	logic [MAX_SLOTS-1:0]  in_range;
	logic [MAX_SLOTS-1:0]  stop;
	logic [MAX_SLOTS-1:0]  hitf;
	slot_t                 slots [MAX_SLOTS];
	logic                  pick_hit;
	logic [HANDLE_W-1:0]   pick_handle;
	logic [STATUS_W-1:0]   res_status;
	logic                  res_hit;
	logic [HANDLE_W-1:0]   res_handle;
	logic                  out_free;
	logic                  res_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_SLOTS);
	assign prdata = APB_DATA_W'(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_wr) begin
			active_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	// sizes above the slot count use the whole row
	assign act_ext = AW'(active_q);
	assign max_ext = AW'(MAX_SLOTS);
	assign used    = (act_ext > max_ext) ? max_ext : act_ext;
	assign add_ok  = (item_s1.handle != '0) && (used != '0);

	assign ctrl.add     = (state_q == S_EXEC) && (mode_s1 == MODE_ADD) && add_ok;
	assign ctrl.clear   = cfg_wr || ((state_q == S_EXEC) && (mode_s1 == MODE_CLEAR));
	assign ctrl.compare = (state_q == S_EXEC) && (mode_s1 == MODE_LOOKUP);

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		slot_t prev;

		assign in_range[i] = (AW'(i) < used);

		if (i == 0) begin : g_head
			assign prev = item_s1;
		end else begin : g_tail
			assign prev = slots[i-1];
		end

		mslc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.in_range  (in_range[i]),
			.query     (item_s1),
			.prev_slot (prev),
			.slot      (slots[i]),
			.stop      (stop[i]),
			.hit       (hitf[i])
		);
	end

	mslc_pick #(
		.N (MAX_SLOTS)
	) u_pick (
		.stop   (stop),
		.hitf   (hitf),
		.slots  (slots),
		.hit    (pick_hit),
		.handle (pick_handle)
	);

	always_comb begin
		res_status = ST_OK;
		res_hit    = 1'b0;
		res_handle = '0;
		case (mode_s1)
			MODE_ADD: begin
				if (item_s1.handle == '0) begin
					res_status = ST_NULL;
				end else if (used == '0) begin
					res_status = ST_SIZE_ZERO;
				end
			end
			MODE_LOOKUP: begin
				res_hit    = pick_hit;
				res_handle = pick_handle;
			end
			MODE_CLEAR: begin
				res_status = ST_OK;
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign res_load = (state_q == S_DONE) && out_free;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1        <= mode_t'(s_tuser);
			item_s1.sec    <= s_tdata[TAG_W-1:0];
			item_s1.key    <= s_tdata[2*TAG_W-1:TAG_W];
			item_s1.handle <= s_tdata[IN_DATA_W-1:2*TAG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= OUT_DATA_W'({res_handle, res_hit, res_status});
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
